>>> design/i2cm_pkg.sv
// i2cm_pkg: shared types, codes and widths for the i2c register access master
// no dependencies
`timescale 1ns / 1ps
package i2cm_pkg;
  localparam int CntW = 16;
  localparam logic [3:0] RecoveryPulses = 4'd9;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0, ACT_READ = 3'd1, ACT_WRITE = 3'd2, ACT_PROBE = 3'd3, ACT_RECOVER = 3'd4,
    ACT_RSV5 = 3'd5, ACT_RSV6 = 3'd6, ACT_RSV7 = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    REG_HIGH = 3'd0, REG_SETUP = 3'd1, REG_HOLD = 3'd2, REG_STST = 3'd3,
    REG_BUF = 3'd4, REG_TIMEOUT = 3'd5, REG_RECOV = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NACK = 3'd1, ST_BUS = 3'd2, ST_BUSY = 3'd3, ST_STUCK = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       scl_in;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] read_data;
    logic       read_valid;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic [15:0] high_t;
    logic [15:0] setup_t;
    logic [15:0] hold_t;
    logic [15:0] stst_t;
    logic [15:0] buf_t;
    logic [15:0] tmo_t;
    logic [15:0] rec_t;
  } timing_t;

  localparam int QDepth = 2;
endpackage

>>> design/i2cm_if.sv
// i2cm_req_if / i2cm_res_if: valid/ready channels for requests and results
// depends on i2cm_pkg
`timescale 1ns / 1ps
interface i2cm_req_if;
  logic valid;
  logic ready;
  i2cm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
  logic valid;
  logic ready;
  i2cm_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/i2cm_front.sv
// i2cm_front: accepts requests, holds config, classifies actions into a queue
// depends on i2cm_pkg
`timescale 1ns / 1ps
module i2cm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cm_pkg::req_t        in_data_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_wdata_i,
  output i2cm_pkg::timing_t     timing_o,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output i2cm_pkg::req_t        q_data_o
);
  import i2cm_pkg::*;

  timing_t tm_q;
  req_t    mem_q [QDepth];
  logic    wp_q, rp_q;
  logic [1:0] cnt_q;
  logic    push;

  function automatic logic [15:0] lim(input logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_q <= '{16'd5, 16'd3, 16'd3, 16'd5, 16'd5, 16'd255, 16'd10};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HIGH:    tm_q.high_t  <= lim(cfg_wdata_i);
        REG_SETUP:   tm_q.setup_t <= lim(cfg_wdata_i);
        REG_HOLD:    tm_q.hold_t  <= lim(cfg_wdata_i);
        REG_STST:    tm_q.stst_t  <= lim(cfg_wdata_i);
        REG_BUF:     tm_q.buf_t   <= lim(cfg_wdata_i);
        REG_TIMEOUT: tm_q.tmo_t   <= lim(cfg_wdata_i);
        REG_RECOV:   tm_q.rec_t   <= lim(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign in_ready_o = (cnt_q != 2'(QDepth)) || q_pop_i;
  assign push = in_valid_i && in_ready_o;

  // unused action codes become plain ticks
  req_t cls;
  always_comb begin
    cls = in_data_i;
    if (in_data_i.action > ACT_RECOVER) cls.action = ACT_TICK;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_data_o  = mem_q[rp_q];
  assign timing_o  = tm_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue overfill");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push lost");
endmodule

>>> design/i2cm_back.sv
// i2cm_back: bus sequencer, one tick per queued request, registered result
// depends on i2cm_pkg
`timescale 1ns / 1ps
module i2cm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cm_pkg::timing_t timing_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  i2cm_pkg::req_t    q_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cm_pkg::res_t    out_data_o
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_WAIT, PH_START_SU, PH_START_HD, PH_START_LOW, PH_BIT_SETUP,
    PH_BIT_RISE, PH_BIT_HIGH, PH_BIT_HOLD, PH_WLOAD, PH_RS_IDLE, PH_RS_SDA_WAIT,
    PH_RS_SU, PH_RS_RISE, PH_RS_SUSTA, PH_STOP_SETUP, PH_STOP_RISE, PH_STOP_SU,
    PH_STOP_BUF, PH_REC_SETTLE, PH_REC_LOW, PH_REC_RISE, PH_REC_HIGH, PH_REC_DROP
  } phase_e;

  typedef enum logic [2:0] {
    SG_SLAW, SG_REG, SG_SLAR, SG_WDATA, SG_RDATA
  } stage_e;

  phase_e ph_q, ph_d;
  stage_e sg_q, sg_d;
  logic [2:0] cmd_q, cmd_d, fs_q, fs_d;
  logic [3:0] bc_q, bc_d, pc_q, pc_d;
  logic [7:0] bl_q, bl_d, sh_q, sh_d, rl_q, rl_d;
  logic [6:0] tl_q, tl_d;
  logic [CntW-1:0] dc_q, dc_d, wc_q, wc_d;
  logic scl_q, scl_d, sda_q, sda_d;
  res_t res_q, res_d;
  logic ov_q;
  logic [15:0] dl;
  logic dexp, wexp, step;
  logic s_done, s_valid, s_req;
  logic [7:0] s_data;
  req_t r;

  assign step    = q_valid_i && (!ov_q || out_ready_i);
  assign q_pop_o = step;
  assign r       = q_data_i;

  always_comb begin
    unique case (ph_q)
      PH_START_SU, PH_RS_SUSTA, PH_STOP_SU:         dl = timing_i.stst_t;
      PH_START_HD, PH_START_LOW, PH_BIT_HOLD, PH_REC_DROP: dl = timing_i.hold_t;
      PH_BIT_HIGH:                                  dl = timing_i.high_t;
      PH_STOP_BUF:                                  dl = timing_i.buf_t;
      PH_REC_SETTLE, PH_REC_LOW, PH_REC_HIGH:       dl = timing_i.rec_t;
      default:                                      dl = timing_i.setup_t;
    endcase
  end
  // compare in one wider bit so the +1 never wraps
  assign dexp = ({1'b0, dc_q} + 17'd1) >= {1'b0, dl};
  assign wexp = ({1'b0, wc_q} + 17'd1) >= {1'b0, timing_i.tmo_t};

  function automatic logic sda_for(input logic [3:0] bc, input stage_e sg,
                                   input logic [7:0] sh, input logic [7:0] bl);
    if (bc < 4'd8) return (sg == SG_RDATA) ? 1'b0 : ~sh[7];
    return (sg == SG_RDATA) ? (bl > 8'd1) : 1'b0;
  endfunction

  always_comb begin
    ph_d = ph_q; sg_d = sg_q; cmd_d = cmd_q; fs_d = fs_q; bc_d = bc_q; pc_d = pc_q;
    bl_d = bl_q; sh_d = sh_q; rl_d = rl_q; tl_d = tl_q; dc_d = dc_q; wc_d = wc_q;
    scl_d = scl_q; sda_d = sda_q;
    s_done = 1'b0; s_valid = 1'b0; s_req = 1'b0; s_data = '0;
    if (!dexp) dc_d = dc_q + 1'b1;
    unique case (ph_q)
      PH_IDLE: begin
        dc_d = dc_q;
        if (r.action == ACT_READ || r.action == ACT_WRITE || r.action == ACT_PROBE) begin
          cmd_d = r.action; tl_d = r.slave_address; rl_d = r.register_address;
          bl_d = r.byte_count; fs_d = ST_OK; sg_d = SG_SLAW;
          sh_d = {r.slave_address, 1'b0}; wc_d = '0;
          ph_d = PH_START_WAIT; scl_d = 0; sda_d = 0; dc_d = '0;
        end else if (r.action == ACT_RECOVER) begin
          cmd_d = r.action; fs_d = ST_OK; pc_d = '0; wc_d = '0;
          ph_d = PH_REC_SETTLE; scl_d = 0; sda_d = 0; dc_d = '0;
        end
      end
      default: ;
    endcase
    // remaining phases use the shared counters
    if (ph_q != PH_IDLE) begin
      logic tnext;
      tnext = 1'b0;
      unique case (ph_q)
        PH_START_WAIT: begin
          dc_d = dc_q;
          if (r.scl_in && r.sda_in) begin ph_d = PH_START_SU; dc_d = '0; end
          else if (wexp) begin fs_d = ST_BUSY; s_done = 1; ph_d = PH_IDLE; scl_d = 0;
            sda_d = 0; dc_d = '0; end
          else wc_d = wc_q + 1'b1;
        end
        PH_START_SU: if (dexp) begin ph_d = PH_START_HD; sda_d = 1; dc_d = '0; end
        PH_START_HD: if (dexp) begin ph_d = PH_START_LOW; scl_d = 1; sda_d = 1; dc_d = '0; end
        PH_START_LOW: if (dexp) begin
          bc_d = '0; ph_d = PH_BIT_SETUP; scl_d = 1; sda_d = sda_for(4'd0, sg_q, sh_q, bl_q);
          dc_d = '0;
        end
        PH_BIT_SETUP: if (dexp) begin wc_d = '0; ph_d = PH_BIT_RISE; scl_d = 0; dc_d = '0; end
        PH_BIT_RISE: begin
          dc_d = dc_q;
          if (r.scl_in) begin ph_d = PH_BIT_HIGH; dc_d = '0; end
          else if (wexp) begin
            if ((bc_q < 4'd8) == (sg_q == SG_RDATA)) begin
              fs_d = ST_BUS; ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1; dc_d = '0;
            end else begin
              fs_d = ST_BUS; s_done = 1; ph_d = PH_IDLE; scl_d = 0; sda_d = 0; dc_d = '0;
            end
          end else wc_d = wc_q + 1'b1;
        end
        PH_BIT_HIGH: if (dexp) begin
          if (bc_q < 4'd8) begin
            sh_d = {sh_q[6:0], r.sda_in};
            if (sg_q == SG_RDATA && bc_q == 4'd7) begin s_valid = 1; s_data = sh_d; end
          end else if (sg_q != SG_RDATA) sh_d = {7'd0, r.sda_in};
          ph_d = PH_BIT_HOLD; scl_d = 1; dc_d = '0;
        end
        PH_BIT_HOLD: if (dexp) begin
          dc_d = '0;
          if (bc_q < 4'd8) begin
            bc_d = bc_q + 1'b1; ph_d = PH_BIT_SETUP; scl_d = 1;
            sda_d = sda_for(bc_d, sg_q, sh_q, bl_q);
          end else if (sg_q == SG_RDATA) begin
            bl_d = (bl_q != 0) ? bl_q - 1'b1 : bl_q;
            if (bl_d == 0) begin ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1; end
            else tnext = 1'b1;
          end else if (sh_q[0]) begin
            fs_d = ST_NACK; ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1;
          end else begin
            unique case (sg_q)
              SG_SLAW: if (cmd_q == ACT_PROBE) begin
                  ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1;
                end else begin
                  sg_d = SG_REG; sh_d = rl_q; bc_d = '0; ph_d = PH_BIT_SETUP; scl_d = 1;
                  sda_d = ~rl_q[7];
                end
              SG_REG: if (cmd_q == ACT_READ) begin
                  wc_d = '0; ph_d = PH_RS_IDLE; scl_d = 1; sda_d = 0;
                end else if (bl_q == 0) begin
                  ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1;
                end else begin s_req = 1; ph_d = PH_WLOAD; scl_d = 1; sda_d = 0; end
              SG_SLAR: if (bl_q == 0) begin ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1; end
                else tnext = 1'b1;
              default: begin
                bl_d = (bl_q != 0) ? bl_q - 1'b1 : bl_q;
                if (bl_d == 0) begin ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1; end
                else begin s_req = 1; ph_d = PH_WLOAD; scl_d = 1; sda_d = 0; end
              end
            endcase
          end
          if (tnext) begin
            sg_d = SG_RDATA; sh_d = '0; bc_d = '0; ph_d = PH_BIT_SETUP; scl_d = 1; sda_d = 0;
          end
        end
        PH_WLOAD: begin
          sg_d = SG_WDATA; sh_d = r.write_data; bc_d = '0; ph_d = PH_BIT_SETUP;
          scl_d = 1; sda_d = ~r.write_data[7]; dc_d = '0;
        end
        PH_RS_IDLE: if (dexp) begin ph_d = PH_RS_SDA_WAIT; scl_d = 1; sda_d = 0; dc_d = '0; end
        PH_RS_SDA_WAIT: begin
          dc_d = dc_q;
          if (r.sda_in) begin ph_d = PH_RS_SU; dc_d = '0; end
          else if (wexp) begin fs_d = ST_BUS; s_done = 1; ph_d = PH_IDLE; scl_d = 0;
            sda_d = 0; dc_d = '0; end
          else wc_d = wc_q + 1'b1;
        end
        PH_RS_SU: if (dexp) begin ph_d = PH_RS_RISE; scl_d = 0; sda_d = 0; dc_d = '0; end
        PH_RS_RISE: begin
          dc_d = dc_q;
          if (r.scl_in) begin ph_d = PH_RS_SUSTA; dc_d = '0; end
          else if (wexp) begin fs_d = ST_BUS; s_done = 1; ph_d = PH_IDLE; scl_d = 0;
            sda_d = 0; dc_d = '0; end
          else wc_d = wc_q + 1'b1;
        end
        PH_RS_SUSTA: if (dexp) begin
          sg_d = SG_SLAR; sh_d = {tl_q, 1'b1}; ph_d = PH_START_HD; scl_d = 0; sda_d = 1;
          dc_d = '0;
        end
        PH_STOP_SETUP: if (dexp) begin wc_d = '0; ph_d = PH_STOP_RISE; scl_d = 0; dc_d = '0; end
        PH_STOP_RISE: begin
          dc_d = dc_q;
          if (r.scl_in) begin ph_d = PH_STOP_SU; dc_d = '0; end
          else if (wexp) begin fs_d = ST_BUS; ph_d = PH_STOP_SU; dc_d = '0; end
          else wc_d = wc_q + 1'b1;
        end
        PH_STOP_SU: if (dexp) begin ph_d = PH_STOP_BUF; sda_d = 0; dc_d = '0; end
        PH_STOP_BUF: if (dexp) begin s_done = 1; ph_d = PH_IDLE; scl_d = 0; sda_d = 0;
          dc_d = '0; end
        PH_REC_SETTLE: if (dexp) begin
          dc_d = '0;
          if (r.scl_in && r.sda_in) begin fs_d = ST_OK; s_done = 1; ph_d = PH_IDLE; end
          else if (!r.sda_in) begin ph_d = PH_REC_LOW; scl_d = 1; end
          else begin fs_d = ST_BUS; s_done = 1; ph_d = PH_IDLE; end
        end
        PH_REC_LOW: if (dexp) begin ph_d = PH_REC_RISE; scl_d = 0; dc_d = '0; end
        PH_REC_RISE: begin
          dc_d = dc_q;
          if (r.scl_in) begin ph_d = PH_REC_HIGH; dc_d = '0; end
          else if (wexp) begin fs_d = ST_BUS; s_done = 1; ph_d = PH_IDLE; scl_d = 0;
            dc_d = '0; end
          else wc_d = wc_q + 1'b1;
        end
        PH_REC_HIGH: if (dexp) begin
          dc_d = '0;
          if (r.sda_in) begin fs_d = ST_OK; ph_d = PH_REC_DROP; scl_d = 1; end
          else begin
            pc_d = pc_q + 1'b1;
            if (pc_d >= RecoveryPulses) begin fs_d = ST_STUCK; s_done = 1; ph_d = PH_IDLE;
              scl_d = 0; end
            else begin ph_d = PH_REC_LOW; scl_d = 1; end
          end
        end
        PH_REC_DROP: if (dexp) begin ph_d = PH_STOP_SETUP; scl_d = 1; sda_d = 1; dc_d = '0; end
        default: begin ph_d = PH_IDLE; scl_d = 0; sda_d = 0; dc_d = '0; end
      endcase
    end
    res_d.scl_low = scl_d; res_d.sda_low = sda_d; res_d.read_data = s_data;
    res_d.read_valid = s_valid; res_d.byte_request = s_req;
    res_d.busy_res = ph_d != PH_IDLE; res_d.done_res = s_done;
    res_d.status = s_done ? fs_d : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; sg_q <= SG_SLAW; cmd_q <= '0; fs_q <= '0; bc_q <= '0; pc_q <= '0;
      bl_q <= '0; sh_q <= '0; rl_q <= '0; tl_q <= '0; dc_q <= '0; wc_q <= '0;
      scl_q <= 1'b0; sda_q <= 1'b0; ov_q <= 1'b0; res_q <= '0;
    end else begin
      if (step) begin
        ph_q <= ph_d; sg_q <= sg_d; cmd_q <= cmd_d; fs_q <= fs_d; bc_q <= bc_d; pc_q <= pc_d;
        bl_q <= bl_d; sh_q <= sh_d; rl_q <= rl_d; tl_q <= tl_d; dc_q <= dc_d; wc_q <= wc_d;
        scl_q <= scl_d; sda_q <= sda_d; res_q <= res_d;
      end
      if (step) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.done_res) |-> !res_q.busy_res) else $error("done while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> $stable(res_q)) else $error("result changed under stall");
  a_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.read_valid) |-> res_q.busy_res) else $error("read byte outside command");
endmodule

>>> design/i2c_master_register_access.sv
// i2c_master_register_access: top level, front queue plus bus sequencer
// depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_back
//
// channel | dir | payload
// in      | in  | action, addresses, byte_count, write_data, scl_in, sda_in
// out     | out | scl_low, sda_low, read_data, read_valid, byte_request, busy, done, status
// cfg     | in  | cfg_we_i, cfg_index_i, cfg_wdata_i (7 timing registers)
//
// one request per cycle unless the output stalls; each is one bus tick with one result
// requests go through a two-entry queue, results through one output register
// requests pass a queue entry, then the output register; a stalled output fills the queue
// reset: idle, lines released, timing registers at defaults
`timescale 1ns / 1ps
module i2c_master_register_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_req_if.sink    in_if,
  i2cm_res_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import i2cm_pkg::*;

  timing_t tm;
  logic q_valid, q_pop;
  req_t q_data;

  i2cm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .timing_o(tm), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  i2cm_back u_back (
    .clk_i, .rst_ni, .timing_i(tm),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

>>> tb/i2c_master_register_access_test.sv
// i2c_master_register_access_test: self-checking bench for the i2c register access master
// depends on i2cm_pkg, i2cm_if and the i2c_master_register_access top level
`timescale 1ns / 1ps
module i2c_master_register_access_test;
  import i2cm_pkg::*;

  localparam logic [4:0] P_IDLE = 5'd0, P_START_WAIT = 5'd1, P_START_SU = 5'd2,
    P_START_HD = 5'd3, P_START_LOW = 5'd4, P_BIT_SETUP = 5'd5, P_BIT_RISE = 5'd6,
    P_BIT_HIGH = 5'd7, P_BIT_HOLD = 5'd8, P_WLOAD = 5'd9, P_RS_IDLE = 5'd10,
    P_RS_SDA_WAIT = 5'd11, P_RS_SU = 5'd12, P_RS_RISE = 5'd13, P_RS_SUSTA = 5'd14,
    P_STOP_SETUP = 5'd15, P_STOP_RISE = 5'd16, P_STOP_SU = 5'd17, P_STOP_BUF = 5'd18,
    P_REC_SETTLE = 5'd19, P_REC_LOW = 5'd20, P_REC_RISE = 5'd21, P_REC_HIGH = 5'd22,
    P_REC_DROP = 5'd23;
  localparam logic [2:0] S_SLAW = 3'd0, S_REG = 3'd1, S_SLAR = 3'd2, S_WDATA = 3'd3,
    S_RDATA = 3'd4;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [15:0] cfg_wdata_i;

  i2cm_req_if in_if ();
  i2cm_res_if out_if ();

  i2c_master_register_access u_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  // bus sequencer shadow
  logic [15:0] tm [7];
  logic [4:0] ph = P_IDLE;
  logic [2:0] cmd_r = '0, stg = '0, fstat = '0;
  logic [3:0] bitn = '0, pulses = '0;
  logic [7:0] left_n = '0, shreg = '0, regp = '0;
  logic [6:0] tgt = '0;
  logic scl_dr = 1'b0, sda_dr = 1'b0;
  int unsigned dly = 0, wcnt = 0;
  logic o_done, o_valid, o_req;
  logic [7:0] o_data;

  res_t expected_q[$];
  req_t pend_q[$];
  int errors = 0, items_sent = 0, done_total = 0, bytes_read = 0, phases_run = 0;
  int status_seen [5] = '{default: 0};
  bit quiet = 1'b0;

  // line behavior of the simulated slave
  int nack_pct = 0, stretch_pct = 0, noise_pct = 0, busy_pct = 0;
  int scl_stuck_left = 0, sda_stuck_left = 0;

  function automatic int unsigned lim_of(logic [15:0] t);
    return (t == 16'd0) ? 1 : t;
  endfunction

  function void go(logic [4:0] p, logic c, logic d);
    ph = p; scl_dr = c; sda_dr = d; dly = 0;
  endfunction

  function void finish_cmd(logic [2:0] s);
    fstat = s; o_done = 1'b1; go(P_IDLE, 1'b0, 1'b0);
  endfunction

  function logic delay_done(logic [15:0] t);
    if (dly + 1 >= lim_of(t)) return 1'b1;
    dly = dly + 1;
    return 1'b0;
  endfunction

  function logic wait_expired();
    if (wcnt + 1 >= lim_of(tm[REG_TIMEOUT])) return 1'b1;
    wcnt = wcnt + 1;
    return 1'b0;
  endfunction

  function logic bit_sda_low();
    if (bitn < 8) return (stg == S_RDATA) ? 1'b0 : !shreg[7];
    if (stg == S_RDATA) return left_n > 1;
    return 1'b0;
  endfunction

  function void start_bit();
    go(P_BIT_SETUP, 1'b1, bit_sda_low());
  endfunction

  function void begin_byte(logic [2:0] s, logic [7:0] v);
    stg = s; shreg = v; bitn = '0; start_bit();
  endfunction

  function void next_write();
    if (left_n == 0) go(P_STOP_SETUP, 1'b1, 1'b1);
    else begin
      o_req = 1'b1; go(P_WLOAD, 1'b1, 1'b0);
    end
  endfunction

  function void after_bit();
    if (bitn < 8) begin
      bitn++; start_bit();
    end else if (stg == S_RDATA) begin
      if (left_n != 0) left_n--;
      if (left_n == 0) go(P_STOP_SETUP, 1'b1, 1'b1);
      else begin_byte(S_RDATA, 8'h00);
    end else if (shreg[0]) begin
      fstat = ST_NACK; go(P_STOP_SETUP, 1'b1, 1'b1);
    end else begin
      case (stg)
        S_SLAW: begin
          if (cmd_r == ACT_PROBE) go(P_STOP_SETUP, 1'b1, 1'b1);
          else begin_byte(S_REG, regp);
        end
        S_REG: begin
          if (cmd_r == ACT_READ) begin
            wcnt = 0; go(P_RS_IDLE, 1'b1, 1'b0);
          end else next_write();
        end
        S_SLAR: begin
          if (left_n == 0) go(P_STOP_SETUP, 1'b1, 1'b1);
          else begin_byte(S_RDATA, 8'h00);
        end
        default: begin
          if (left_n != 0) left_n--;
          next_write();
        end
      endcase
    end
  endfunction

  function res_t predict_tick(req_t r);
    res_t e;
    o_done = 1'b0; o_valid = 1'b0; o_req = 1'b0; o_data = '0;
    case (ph)
      P_IDLE: begin
        if (r.action inside {ACT_READ, ACT_WRITE, ACT_PROBE}) begin
          cmd_r = r.action; tgt = r.slave_address; regp = r.register_address;
          left_n = r.byte_count; fstat = ST_OK; stg = S_SLAW; shreg = {tgt, 1'b0};
          wcnt = 0; go(P_START_WAIT, 1'b0, 1'b0);
        end else if (r.action == ACT_RECOVER) begin
          cmd_r = r.action; fstat = ST_OK; pulses = '0; wcnt = 0;
          go(P_REC_SETTLE, 1'b0, 1'b0);
        end
      end
      P_START_WAIT: begin
        if (r.scl_in && r.sda_in) go(P_START_SU, 1'b0, 1'b0);
        else if (wait_expired()) finish_cmd(ST_BUSY);
      end
      P_START_SU: if (delay_done(tm[REG_STST])) go(P_START_HD, 1'b0, 1'b1);
      P_START_HD: if (delay_done(tm[REG_HOLD])) go(P_START_LOW, 1'b1, 1'b1);
      P_START_LOW: begin
        if (delay_done(tm[REG_HOLD])) begin
          bitn = '0; start_bit();
        end
      end
      P_BIT_SETUP: begin
        if (delay_done(tm[REG_SETUP])) begin
          wcnt = 0; go(P_BIT_RISE, 1'b0, sda_dr);
        end
      end
      P_BIT_RISE: begin
        if (r.scl_in) go(P_BIT_HIGH, 1'b0, sda_dr);
        else if (wait_expired()) begin
          // a timeout on a bit the slave drives still gets a stop
          if ((bitn < 8) == (stg == S_RDATA)) begin
            fstat = ST_BUS; go(P_STOP_SETUP, 1'b1, 1'b1);
          end else finish_cmd(ST_BUS);
        end
      end
      P_BIT_HIGH: begin
        if (delay_done(tm[REG_HIGH])) begin
          if (bitn < 8) begin
            shreg = {shreg[6:0], r.sda_in};
            if (stg == S_RDATA && bitn == 7) begin
              o_valid = 1'b1; o_data = shreg;
            end
          end else if (stg != S_RDATA) shreg = {7'd0, r.sda_in};
          go(P_BIT_HOLD, 1'b1, sda_dr);
        end
      end
      P_BIT_HOLD: if (delay_done(tm[REG_HOLD])) after_bit();
      P_WLOAD: begin_byte(S_WDATA, r.write_data);
      P_RS_IDLE: if (delay_done(tm[REG_SETUP])) go(P_RS_SDA_WAIT, 1'b1, 1'b0);
      P_RS_SDA_WAIT: begin
        if (r.sda_in) go(P_RS_SU, 1'b1, 1'b0);
        else if (wait_expired()) finish_cmd(ST_BUS);
      end
      P_RS_SU: if (delay_done(tm[REG_SETUP])) go(P_RS_RISE, 1'b0, 1'b0);
      P_RS_RISE: begin
        if (r.scl_in) go(P_RS_SUSTA, 1'b0, 1'b0);
        else if (wait_expired()) finish_cmd(ST_BUS);
      end
      P_RS_SUSTA: begin
        if (delay_done(tm[REG_STST])) begin
          stg = S_SLAR; shreg = {tgt, 1'b1}; go(P_START_HD, 1'b0, 1'b1);
        end
      end
      P_STOP_SETUP: begin
        if (delay_done(tm[REG_SETUP])) begin
          wcnt = 0; go(P_STOP_RISE, 1'b0, 1'b1);
        end
      end
      P_STOP_RISE: begin
        if (r.scl_in) go(P_STOP_SU, 1'b0, 1'b1);
        else if (wait_expired()) begin
          fstat = ST_BUS; go(P_STOP_SU, 1'b0, 1'b1);
        end
      end
      P_STOP_SU: if (delay_done(tm[REG_STST])) go(P_STOP_BUF, 1'b0, 1'b0);
      P_STOP_BUF: if (delay_done(tm[REG_BUF])) finish_cmd(fstat);
      P_REC_SETTLE: begin
        if (delay_done(tm[REG_RECOV])) begin
          if (r.scl_in && r.sda_in) finish_cmd(ST_OK);
          else if (!r.sda_in) go(P_REC_LOW, 1'b1, 1'b0);
          else finish_cmd(ST_BUS);
        end
      end
      P_REC_LOW: if (delay_done(tm[REG_RECOV])) go(P_REC_RISE, 1'b0, 1'b0);
      P_REC_RISE: begin
        if (r.scl_in) go(P_REC_HIGH, 1'b0, 1'b0);
        else if (wait_expired()) finish_cmd(ST_BUS);
      end
      P_REC_HIGH: begin
        if (delay_done(tm[REG_RECOV])) begin
          if (r.sda_in) begin
            fstat = ST_OK; go(P_REC_DROP, 1'b1, 1'b0);
          end else begin
            pulses = pulses + 4'd1;
            if (pulses >= RecoveryPulses) finish_cmd(ST_STUCK);
            else go(P_REC_LOW, 1'b1, 1'b0);
          end
        end
      end
      P_REC_DROP: if (delay_done(tm[REG_HOLD])) go(P_STOP_SETUP, 1'b1, 1'b1);
      default: go(P_IDLE, 1'b0, 1'b0);
    endcase
    e.scl_low = scl_dr;
    e.sda_low = sda_dr;
    e.read_data = o_data;
    e.read_valid = o_valid;
    e.byte_request = o_req;
    e.busy_res = ph != P_IDLE;
    e.done_res = o_done;
    e.status = o_done ? fstat : 3'd0;
    if (o_done) begin
      done_total++;
      status_seen[fstat]++;
    end
    if (o_valid) bytes_read++;
    return e;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver, prediction taken at acceptance
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) expected_q.push_back(predict_tick(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 4);
          in_if.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.data <= pend_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  function void check_field(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  // result monitor with random back-pressure
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e, a;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        a = out_if.data;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("scl_low", e.scl_low, a.scl_low);
          check_field("sda_low", e.sda_low, a.sda_low);
          check_field("read_data", e.read_data, a.read_data);
          check_field("read_valid", e.read_valid, a.read_valid);
          check_field("byte_request", e.byte_request, a.byte_request);
          check_field("busy_res", e.busy_res, a.busy_res);
          check_field("done_res", e.done_res, a.done_res);
          check_field("status", e.status, a.status);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // one bus tick as the slave and the wires would show it
  function req_t bus_tick(action_e a);
    req_t r;
    r.action = a;
    r.slave_address = 7'($urandom);
    r.register_address = 8'($urandom);
    r.byte_count = 8'($urandom);
    r.write_data = 8'($urandom);
    if (scl_stuck_left > 0) begin
      scl_stuck_left--;
      r.scl_in = 1'b0;
    end else if (scl_dr) r.scl_in = 1'b0;
    // the slave only stretches while the master waits for a rising clock
    else if (ph inside {P_BIT_RISE, P_RS_RISE, P_STOP_RISE, P_REC_RISE})
      r.scl_in = $urandom_range(0, 99) >= stretch_pct;
    else r.scl_in = 1'b1;
    if (sda_stuck_left > 0) begin
      sda_stuck_left--;
      r.sda_in = 1'b0;
    end else if (sda_dr) r.sda_in = 1'b0;
    else if (bitn == 8 && stg != S_RDATA) r.sda_in = $urandom_range(0, 99) < nack_pct;
    else r.sda_in = 1'($urandom);
    if ($urandom_range(0, 99) < noise_pct) r.sda_in = ~r.sda_in;
    if ($urandom_range(0, 99) < noise_pct) r.scl_in = ~r.scl_in;
    return r;
  endfunction

  task push_item(req_t r);
    while (pend_q.size() != 0) @(posedge clk_i);
    pend_q.push_back(r);
    items_sent++;
  endtask

  task run_cmd(action_e a, int cnt);
    req_t r;
    int start;
    start = done_total;
    r = bus_tick(a);
    r.byte_count = 8'(cnt);
    push_item(r);
    while (done_total == start) begin
      // commands issued mid-transfer must be ignored
      if (ph != P_IDLE && $urandom_range(0, 99) < busy_pct)
        push_item(bus_tick(action_e'($urandom_range(1, 7))));
      else push_item(bus_tick(ACT_TICK));
    end
    repeat ($urandom_range(0, 3)) push_item(bus_tick(action_e'($urandom_range(5, 7))));
  endtask

  task settle();
    bit idle;
    idle = 1'b0;
    while (!idle) begin
      while (pend_q.size() != 0 || in_if.valid) @(posedge clk_i);
      if (ph == P_IDLE) idle = 1'b1;
      else push_item(bus_tick(ACT_TICK));
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task cfg_write(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    tm[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task random_traffic(int quota);
    int stop_at, pick, cnt;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      nack_pct = ($urandom_range(0, 3) == 0) ? 40 : 3;
      stretch_pct = $urandom_range(0, 2) * 15;
      noise_pct = ($urandom_range(0, 7) == 0) ? 3 : 0;
      busy_pct = 3;
      if ($urandom_range(0, 29) == 0) scl_stuck_left = $urandom_range(1, 40);
      pick = $urandom_range(0, 9);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      if (pick == 9) begin
        sda_stuck_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
        run_cmd(ACT_RECOVER, 0);
      end else begin
        run_cmd(pick < 4 ? ACT_READ : pick < 7 ? ACT_WRITE : ACT_PROBE, cnt);
      end
    end
    scl_stuck_left = 0;
    sda_stuck_left = 0;
    settle();
  endtask

  task set_timing(int unsigned lo, int unsigned hi, int unsigned tmo);
    for (int i = 0; i < 7; i++)
      cfg_write(reg_idx_e'(i), 16'((i == REG_TIMEOUT) ? tmo : $urandom_range(lo, hi)));
  endtask

  initial begin
    tm = '{16'd5, 16'd3, 16'd3, 16'd5, 16'd5, 16'd255, 16'd10};
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_HIGH;
    cfg_wdata_i <= '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one probe and a recovery under reset timing
    busy_pct = 0;
    run_cmd(ACT_PROBE, 0);
    run_cmd(ACT_RECOVER, 0);
    settle();

    // every command and each bus corner under the shortest timing
    set_timing(1, 1, 8);
    nack_pct = 100;
    run_cmd(ACT_PROBE, 0);
    run_cmd(ACT_WRITE, 255);
    nack_pct = 0;
    run_cmd(ACT_WRITE, 0);
    run_cmd(ACT_WRITE, 2);
    run_cmd(ACT_READ, 0);
    run_cmd(ACT_READ, 3);
    scl_stuck_left = 20;
    run_cmd(ACT_WRITE, 1);
    scl_stuck_left = 0;
    sda_stuck_left = 12;
    run_cmd(ACT_RECOVER, 0);
    sda_stuck_left = 200;
    run_cmd(ACT_RECOVER, 0);
    sda_stuck_left = 0;
    scl_stuck_left = 5;
    run_cmd(ACT_RECOVER, 0);
    scl_stuck_left = 0;
    busy_pct = 30;
    run_cmd(ACT_READ, 2);
    push_item(bus_tick(ACT_RSV5));
    push_item(bus_tick(ACT_RSV6));
    push_item(bus_tick(ACT_RSV7));
    settle();

    // clock stretch timeouts with a short limit, zero values act as one
    cfg_write(REG_HIGH, 16'd0);
    cfg_write(REG_SETUP, 16'd0);
    cfg_write(REG_HOLD, 16'd0);
    cfg_write(REG_STST, 16'd0);
    cfg_write(REG_BUF, 16'd0);
    cfg_write(REG_TIMEOUT, 16'd3);
    cfg_write(REG_RECOV, 16'd0);
    stretch_pct = 100;
    run_cmd(ACT_WRITE, 1);
    run_cmd(ACT_READ, 2);
    stretch_pct = 0;
    settle();
    phases_run = 2;

    // widest values on an idle bus, then back to short timing
    for (int i = 0; i < 7; i++) cfg_write(reg_idx_e'(i), 16'hffff);
    repeat (5) push_item(bus_tick(ACT_TICK));
    settle();

    for (int p = 0; p < 4; p++) begin
      set_timing(1, (p == 0) ? 1 : 2, (p == 1) ? 16'hffff : $urandom_range(2, 20));
      quiet = (p == 3);
      random_traffic(80);
      phases_run++;
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d ticks in %0d timing settings: %0d commands ended, %0d bytes read",
             items_sent, phases_run, done_total, bytes_read);
    $display("status counts ok %0d nack %0d bus %0d busy %0d stuck %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> sim.f
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_master_register_access.sv
tb/i2c_master_register_access_test.sv
